### rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/roicrop_pkg.sv
// Types, constants and tables of the region-of-interest crop filter
`timescale 1ns / 1ps
`default_nettype none
package roicrop_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int MaxTable = 24;
	localparam int CordicN = (CORDIC_STAGES < MaxTable) ? CORDIC_STAGES : MaxTable;

	// widths of the arithmetic
	localparam int DW = 21;   // point minus origin
	localparam int PW = 41;   // one product
	localparam int FW = 43;   // full projection, 18 fraction bits
	localparam int LW = 26;   // rounded local coordinate
	localparam int CW = 44;   // CORDIC x and y
	localparam int CfgW = 60;

	localparam logic [31:0] ATAN_TABLE [MaxTable] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
	};

	typedef enum logic [2:0] {
		CFG_AXIS_X = 3'd0,
		CFG_AXIS_Y = 3'd1,
		CFG_AXIS_Z = 3'd2,
		CFG_ORIGIN = 3'd3,
		CFG_HEIGHT = 3'd4,
		CFG_RANGE  = 3'd5,
		CFG_ANGLE  = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic signed [19:0] point_x;
		logic signed [19:0] point_y;
		logic signed [19:0] point_z;
		logic               point_valid;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic               keep;
		logic signed [19:0] out_x;
		logic signed [19:0] out_y;
		logic signed [19:0] out_z;
		logic               out_last;
	} result_t;

	// keep flag so far plus the point, carried beside the CORDIC
	typedef struct packed {
		logic   keep;
		point_t pt;
	} side_t;

endpackage
`default_nettype wire

### rtl/point_roi_crop_filter_unit.sv
// Top level of the point-cloud region-of-interest crop filter
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Takes one point per cycle while in_stall is low and returns one result per
// point, in order, through three projection stages (origin subtract, 21x20
// multiplies, sums), rounding and height test, squaring, range test, the
// CORDIC setup stage and one stage per rotation, then the angle test into the
// output register. A skid entry behind the output register lets a stalled
// result wait while the pipeline keeps its contents; in_stall rises only when
// that entry is occupied. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while no point is in flight; the block does
// not enforce this. Unknown indexes are ignored.
module point_roi_crop_filter_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire roicrop_pkg::point_t          in_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output roicrop_pkg::result_t              out_data,
	input  wire logic                         cfg_we,
	input  wire logic [2:0]                   cfg_index,
	input  wire logic [roicrop_pkg::CfgW-1:0] cfg_data
);
	logic [roicrop_pkg::CfgW-1:0] axis_x_q, axis_y_q, axis_z_q, origin_q;
	logic [39:0]                  height_q, range_q;
	logic [31:0]                  angle_q;
	logic [39:0]                  rmin2_q, rmax2_q;

	logic adv;
	logic skid_full;

	logic                              valid_s3;
	logic signed [roicrop_pkg::FW-1:0] flx_s3, fly_s3, flz_s3;
	roicrop_pkg::point_t               point_s3;

	logic                              valid_s4, valid_s5, valid_s6;
	logic signed [roicrop_pkg::LW-1:0] lx_s4, ly_s4, lx_s5, ly_s5, lx_s6, ly_s6;
	roicrop_pkg::side_t                side_s4, side_s5, side_s6;
	logic [2*roicrop_pkg::LW-1:0]      lx2_s5, ly2_s5;

	logic signed [roicrop_pkg::FW-1:0] hmin_w, hmax_w;
	logic signed [roicrop_pkg::FW:0]   lx_sum, ly_sum;
	logic [2*roicrop_pkg::LW:0]        r2;

	logic                              cor_valid;
	logic signed [15:0]                cor_angle;
	roicrop_pkg::side_t                cor_side;
	roicrop_pkg::result_t              res;

	assign adv      = !skid_full;
	assign in_stall = skid_full;

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= 60'd262144;
			axis_y_q <= 60'd274877906944;
			axis_z_q <= 60'd288230376151711744;
			origin_q <= '0;
			height_q <= 40'd1048576000;
			range_q  <= 40'd4194304450;
			angle_q  <= 32'd1073790976;
		end else if (cfg_we) begin
			case (cfg_index)
				roicrop_pkg::CFG_AXIS_X: axis_x_q <= cfg_data;
				roicrop_pkg::CFG_AXIS_Y: axis_y_q <= cfg_data;
				roicrop_pkg::CFG_AXIS_Z: axis_z_q <= cfg_data;
				roicrop_pkg::CFG_ORIGIN: origin_q <= cfg_data;
				roicrop_pkg::CFG_HEIGHT: height_q <= cfg_data[39:0];
				roicrop_pkg::CFG_RANGE:  range_q  <= cfg_data[39:0];
				roicrop_pkg::CFG_ANGLE:  angle_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// square the range limits ahead of use
	always_ff @(posedge clk) begin
		rmin2_q <= range_q[19:0] * range_q[19:0];
		rmax2_q <= range_q[39:20] * range_q[39:20];
	end

	roicrop_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (in_valid),
		.in_point (in_data),
		.origin   (origin_q),
		.axis_x   (axis_x_q),
		.axis_y   (axis_y_q),
		.axis_z   (axis_z_q),
		.valid_s3 (valid_s3),
		.flx_s3   (flx_s3),
		.fly_s3   (fly_s3),
		.flz_s3   (flz_s3),
		.point_s3 (point_s3)
	);

	// height bounds at 18 fraction bits, rounding of lx and ly, sum of squares
	always_comb begin
		hmin_w = {{5{height_q[19]}}, height_q[19:0], 18'd0};
		hmax_w = {{5{height_q[39]}}, height_q[39:20], 18'd0};
		lx_sum = 44'(flx_s3) + 44'sd131072;
		ly_sum = 44'(fly_s3) + 44'sd131072;
		r2     = 53'(lx2_s5) + 53'(ly2_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// height test, squares, range test
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.pt   <= point_s3;
			side_s4.keep <= point_s3.point_valid && (flz_s3 >= hmin_w) && (flz_s3 <= hmax_w);
			lx_s4        <= lx_sum[43:18];
			ly_s4        <= ly_sum[43:18];

			side_s5 <= side_s4;
			lx_s5   <= lx_s4;
			ly_s5   <= ly_s4;
			lx2_s5  <= 52'(lx_s4 * lx_s4);
			ly2_s5  <= 52'(ly_s4 * ly_s4);

			side_s6.pt   <= side_s5.pt;
			side_s6.keep <= side_s5.keep && (r2 >= 53'(rmin2_q)) && (r2 <= 53'(rmax2_q));
			lx_s6        <= lx_s5;
			ly_s6        <= ly_s5;
		end
	end

	roicrop_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s6),
		.lx        (lx_s6),
		.ly        (ly_s6),
		.in_side   (side_s6),
		.out_valid (cor_valid),
		.angle     (cor_angle),
		.out_side  (cor_side)
	);

	// angle test and result assembly
	always_comb begin
		res.keep     = cor_side.keep && (cor_angle >= $signed(angle_q[15:0]))
		               && (cor_angle <= $signed(angle_q[31:16]));
		res.out_x    = cor_side.pt.point_x;
		res.out_y    = cor_side.pt.point_y;
		res.out_z    = cor_side.pt.point_z;
		res.out_last = cor_side.pt.last_point;
	end

	roicrop_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_valid),
		.in_data   (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`ASSERT_NEVER(a_skid_without_out, clk, arst_n, skid_full && !out_valid)
	`ASSERT_CLK(a_skid_fill_on_stall, clk, arst_n, $rose(skid_full) |-> $past(out_valid && out_stall))
	`ASSERT_CLK(a_in_stall_drains, clk, arst_n, (skid_full && !out_stall) |=> !skid_full)
endmodule
`default_nettype wire

### rtl/roicrop_proj.sv
// Three-stage projection of a point onto the configured axes
`timescale 1ns / 1ps
`default_nettype none
module roicrop_proj (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire roicrop_pkg::point_t            in_point,
	input  wire logic [roicrop_pkg::CfgW-1:0]   origin,
	input  wire logic [roicrop_pkg::CfgW-1:0]   axis_x,
	input  wire logic [roicrop_pkg::CfgW-1:0]   axis_y,
	input  wire logic [roicrop_pkg::CfgW-1:0]   axis_z,
	output logic                                valid_s3,
	output logic signed [roicrop_pkg::FW-1:0]   flx_s3,
	output logic signed [roicrop_pkg::FW-1:0]   fly_s3,
	output logic signed [roicrop_pkg::FW-1:0]   flz_s3,
	output roicrop_pkg::point_t                 point_s3
);
	logic                                 valid_s1, valid_s2;
	logic signed [roicrop_pkg::DW-1:0]    d_s1 [3];
	logic signed [roicrop_pkg::PW-1:0]    prod_s2 [3][3];
	roicrop_pkg::point_t                  point_s1, point_s2;
	logic signed [roicrop_pkg::DW-1:0]    d_in [3];
	logic [roicrop_pkg::CfgW-1:0]         axes [3];

	assign axes[0] = axis_x;
	assign axes[1] = axis_y;
	assign axes[2] = axis_z;

	// subtract the origin, one component per lane
	always_comb begin
		d_in[0] = 21'(in_point.point_x) - 21'($signed(origin[19:0]));
		d_in[1] = 21'(in_point.point_y) - 21'($signed(origin[39:20]));
		d_in[2] = 21'(in_point.point_z) - 21'($signed(origin[59:40]));
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// difference, nine products, three sums
	always_ff @(posedge clk) begin
		if (en) begin
			point_s1 <= in_point;
			point_s2 <= point_s1;
			point_s3 <= point_s2;
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= d_in[k];
			end
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[a][k] <= d_s1[k] * $signed(axes[a][20*k +: 20]);
				end
			end
			flx_s3 <= 43'(prod_s2[0][0]) + 43'(prod_s2[0][1]) + 43'(prod_s2[0][2]);
			fly_s3 <= 43'(prod_s2[1][0]) + 43'(prod_s2[1][1]) + 43'(prod_s2[1][2]);
			flz_s3 <= 43'(prod_s2[2][0]) + 43'(prod_s2[2][1]) + 43'(prod_s2[2][2]);
		end
	end
endmodule
`default_nettype wire

### rtl/roicrop_cordic.sv
// Pipelined CORDIC in vectoring mode: one register stage per rotation
`timescale 1ns / 1ps
`default_nettype none
module roicrop_cordic (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [roicrop_pkg::LW-1:0] lx,
	input  wire logic signed [roicrop_pkg::LW-1:0] ly,
	input  wire roicrop_pkg::side_t            in_side,
	output logic                               out_valid,
	output logic signed [15:0]                 angle,
	output roicrop_pkg::side_t                 out_side
);
	localparam int N = roicrop_pkg::CordicN;

	logic                                  valid_q [N+1];
	logic signed [roicrop_pkg::CW-1:0]     x_q [N+1];
	logic signed [roicrop_pkg::CW-1:0]     y_q [N+1];
	logic [31:0]                           z_q [N+1];
	logic                                  zero_q [N+1];
	roicrop_pkg::side_t                    side_q [N+1];
	logic signed [roicrop_pkg::CW-1:0]     x_init, y_init;
	logic [31:0]                           z_round;

	// scale by 2^16 before the left half plane is folded onto the right
	always_comb begin
		x_init = {{(roicrop_pkg::CW-roicrop_pkg::LW-16){lx[roicrop_pkg::LW-1]}}, lx, 16'd0};
		y_init = {{(roicrop_pkg::CW-roicrop_pkg::LW-16){ly[roicrop_pkg::LW-1]}}, ly, 16'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q[0] <= 1'b0;
		end else if (en) begin
			valid_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= in_side;
			zero_q[0] <= (lx == '0) && (ly == '0);
			if (lx[roicrop_pkg::LW-1]) begin
				x_q[0] <= -x_init;
				y_q[0] <= -y_init;
				z_q[0] <= 32'h8000_0000;
			end else begin
				x_q[0] <= x_init;
				y_q[0] <= y_init;
				z_q[0] <= 32'd0;
			end
		end
	end

	// rotate toward the x axis, one stage per table entry used
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[i+1] <= 1'b0;
			end else if (en) begin
				valid_q[i+1] <= valid_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i+1] <= side_q[i];
				zero_q[i+1] <= zero_q[i];
				if (!y_q[i][roicrop_pkg::CW-1]) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + roicrop_pkg::ATAN_TABLE[i];
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - roicrop_pkg::ATAN_TABLE[i];
				end
			end
		end
	end

	// round the phase to a 16-bit binary angle
	assign z_round   = z_q[N] + 32'h0000_8000;
	assign angle     = zero_q[N] ? 16'sd0 : $signed(z_round[31:16]);
	assign out_valid = valid_q[N];
	assign out_side  = side_q[N];
endmodule
`default_nettype wire

### rtl/roicrop_skid.sv
// Output register with a skid entry so the pipeline stall is registered
`timescale 1ns / 1ps
`default_nettype none
module roicrop_skid (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire roicrop_pkg::result_t in_data,
	output logic                      full,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output roicrop_pkg::result_t      out_data
);
	logic                 skid_valid_q;
	roicrop_pkg::result_t skid_q;
	logic                 out_take;

	assign out_take = out_valid && !out_stall;
	assign full     = skid_valid_q;

	// track occupancy of the output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid <= in_valid;
			end
		end else if (!out_valid) begin
			out_valid <= in_valid;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// move payload into the output or park it in the skid entry
	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_valid_q) begin
				out_data <= skid_q;
			end else begin
				out_data <= in_data;
			end
		end else if (!out_valid) begin
			out_data <= in_data;
		end else if (!skid_valid_q) begin
			skid_q <= in_data;
		end
	end
endmodule
`default_nettype wire

### tb/point_roi_crop_filter_unit_tb.sv
// Self-checking testbench for the point-cloud region-of-interest crop filter
`timescale 1ns / 1ps
module point_roi_crop_filter_unit_tb;

	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = roicrop_pkg::CORDIC_STAGES + 24;
	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_PHASES = 10;
	localparam int POINTS_PER_PHASE = 200;

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
		logic               vld;
		logic               lst;
		logic               typed;
		logic               keep;
	} row_t;

	localparam row_t DIRECTED [18] = '{
		'{20'sd1000, 20'sd0, 20'sd500, 1'b1, 1'b0, 1'b1, 1'b1},
		'{20'sd1000, 20'sd0, 20'sd500, 1'b0, 1'b0, 1'b1, 1'b0},
		'{20'sd1000, 20'sd0, -20'sd1, 1'b1, 1'b0, 1'b1, 1'b0},
		'{20'sd1000, 20'sd0, 20'sd0, 1'b1, 1'b0, 1'b1, 1'b1},
		'{20'sd1000, 20'sd0, 20'sd1000, 1'b1, 1'b0, 1'b1, 1'b1},
		'{20'sd1000, 20'sd0, 20'sd1001, 1'b1, 1'b0, 1'b1, 1'b0},
		'{20'sd449, 20'sd0, 20'sd10, 1'b1, 1'b0, 1'b1, 1'b0},
		'{20'sd450, 20'sd0, 20'sd10, 1'b1, 1'b0, 1'b1, 1'b1},
		'{20'sd4000, 20'sd0, 20'sd10, 1'b1, 1'b0, 1'b1, 1'b1},
		'{20'sd4001, 20'sd0, 20'sd10, 1'b1, 1'b0, 1'b1, 1'b0},
		'{-20'sd1000, 20'sd0, 20'sd10, 1'b1, 1'b0, 1'b1, 1'b0},
		'{20'sd0, 20'sd0, 20'sd10, 1'b1, 1'b0, 1'b1, 1'b0},
		'{20'sd0, 20'sd1000, 20'sd10, 1'b1, 1'b0, 1'b0, 1'b0},
		'{20'sd0, -20'sd1000, 20'sd10, 1'b1, 1'b0, 1'b0, 1'b0},
		'{20'sd707, -20'sd707, 20'sd10, 1'b1, 1'b1, 1'b0, 1'b0},
		'{20'sd524287, 20'sd524287, 20'sd524287, 1'b1, 1'b1, 1'b1, 1'b0},
		'{-20'sd524288, -20'sd524288, -20'sd524288, 1'b1, 1'b0, 1'b1, 1'b0},
		'{-20'sd524288, 20'sd0, 20'sd0, 1'b0, 1'b1, 1'b1, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	roicrop_pkg::point_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	roicrop_pkg::result_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [roicrop_pkg::CfgW-1:0] cfg_data = '0;

	// shadow of the configuration registers
	logic [59:0] axis_r [3];
	logic [59:0] origin_r;
	logic [39:0] height_r, range_r;
	logic [31:0] angle_r;

	roicrop_pkg::result_t expected_results [$];
	int errors = 0;
	int points_sent = 0;
	int results_seen = 0;
	int kept_seen = 0;
	int cycles = 0;
	bit tx_quiet = 0;
	bit rx_quiet = 0;
	bit rx_hold_req = 0;

	point_roi_crop_filter_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint sx20(logic [19:0] v);
		return longint'($signed(v));
	endfunction

	// full projection of the offset point onto one axis, 18 fraction bits
	function automatic longint project_axis(longint d [3], logic [59:0] ax);
		longint acc;
		acc = 0;
		for (int k = 0; k < 3; k++)
			acc += d[k] * sx20(ax[20*k +: 20]);
		return acc;
	endfunction

	// CORDIC vectoring angle of (lx, ly) as a signed 16-bit binary angle
	function automatic longint cordic_angle(longint lx, longint ly);
		longint x, y, xs, ys;
		logic [31:0] z, zr;
		if (lx == 0 && ly == 0)
			return 0;
		x = lx * 65536;
		y = ly * 65536;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < roicrop_pkg::CORDIC_STAGES && i < roicrop_pkg::MaxTable; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += roicrop_pkg::ATAN_TABLE[i];
			end else begin
				x -= ys;
				y += xs;
				z -= roicrop_pkg::ATAN_TABLE[i];
			end
		end
		zr = z + 32'h8000;
		return longint'($signed(zr[31:16]));
	endfunction

	function automatic roicrop_pkg::result_t crop_result(roicrop_pkg::point_t p);
		longint d [3];
		longint flx, fly, flz, lx, ly, r2, rmin, rmax, ang;
		roicrop_pkg::result_t r;
		r.keep = p.point_valid;
		d[0] = longint'(p.point_x) - sx20(origin_r[19:0]);
		d[1] = longint'(p.point_y) - sx20(origin_r[39:20]);
		d[2] = longint'(p.point_z) - sx20(origin_r[59:40]);
		flx = project_axis(d, axis_r[0]);
		fly = project_axis(d, axis_r[1]);
		flz = project_axis(d, axis_r[2]);
		if (flz < sx20(height_r[19:0]) * 262144 || flz > sx20(height_r[39:20]) * 262144)
			r.keep = 1'b0;
		lx = (flx + 131072) >>> 18;
		ly = (fly + 131072) >>> 18;
		r2 = lx * lx + ly * ly;
		rmin = longint'(range_r[19:0]);
		rmax = longint'(range_r[39:20]);
		if (r2 < rmin * rmin || r2 > rmax * rmax)
			r.keep = 1'b0;
		ang = cordic_angle(lx, ly);
		if (ang < longint'($signed(angle_r[15:0])) || ang > longint'($signed(angle_r[31:16])))
			r.keep = 1'b0;
		r.out_x = p.point_x;
		r.out_y = p.point_y;
		r.out_z = p.point_z;
		r.out_last = p.last_point;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
	endtask

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		roicrop_pkg::result_t want;
		cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.keep !== want.keep)
					report_mismatch("keep", out_data.keep, want.keep);
				if (out_data.out_x !== want.out_x)
					report_mismatch("out_x", out_data.out_x, want.out_x);
				if (out_data.out_y !== want.out_y)
					report_mismatch("out_y", out_data.out_y, want.out_y);
				if (out_data.out_z !== want.out_z)
					report_mismatch("out_z", out_data.out_z, want.out_z);
				if (out_data.out_last !== want.out_last)
					report_mismatch("out_last", out_data.out_last, want.out_last);
			end
			results_seen++;
			if (out_data.keep === 1'b1)
				kept_seen++;
		end
	end

	// abort a hung run
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("point_roi_crop_filter_unit_tb: FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request, none when quiet
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_quiet) begin
				out_stall = 1'b0;
			end else if (rx_hold_req) begin
				rx_hold_req = 0;
				out_stall = 1'b1;
				repeat (300) @(negedge clk);
				out_stall = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 9);
				out_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				n = $urandom_range(1, 20);
				out_stall = 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// offer one point and hold it until accepted; called at a falling edge
	task automatic send_point(roicrop_pkg::point_t p);
		if (!tx_quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = p;
		do @(posedge clk); while (in_stall);
		expected_results = {expected_results, crop_result(p)};
		points_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain_pipeline();
		in_valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [59:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			roicrop_pkg::CFG_AXIS_X: axis_r[0] = val;
			roicrop_pkg::CFG_AXIS_Y: axis_r[1] = val;
			roicrop_pkg::CFG_AXIS_Z: axis_r[2] = val;
			roicrop_pkg::CFG_ORIGIN: origin_r = val;
			roicrop_pkg::CFG_HEIGHT: height_r = val[39:0];
			roicrop_pkg::CFG_RANGE:  range_r = val[39:0];
			roicrop_pkg::CFG_ANGLE:  angle_r = val[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [59:0] rand60();
		return 60'({$urandom, $urandom});
	endfunction

	function automatic logic [19:0] rand_s20(int lim);
		return 20'($signed($urandom_range(0, 2 * lim)) - lim);
	endfunction

	// pick an axis: unit, negated unit, scaled, or arbitrary bits
	function automatic logic [59:0] pick_axis(int home);
		logic [59:0] v;
		int slot;
		slot = $urandom_range(0, 2);
		v = '0;
		case ($urandom_range(0, 6))
			0, 1: v[20*home +: 20] = 20'sd262144;
			2: v[20*home +: 20] = -20'sd262144;
			3: v[20*slot +: 20] = ($urandom_range(0, 1)) ? 20'sd262144 : -20'sd262144;
			4: v = {rand_s20(262144), rand_s20(262144), rand_s20(262144)};
			5: v = rand60();
			default: v = $urandom_range(0, 1) ? '1 : {3{20'h80000}};
		endcase
		return v;
	endfunction

	task automatic configure_random();
		logic [19:0] a, b;
		logic [15:0] c, e;
		for (int k = 0; k < 3; k++)
			write_reg(3'(k), pick_axis(k));
		case ($urandom_range(0, 3))
			0: write_reg(roicrop_pkg::CFG_ORIGIN, '0);
			1: write_reg(roicrop_pkg::CFG_ORIGIN, rand60());
			default: write_reg(roicrop_pkg::CFG_ORIGIN,
				{rand_s20(2000), rand_s20(2000), rand_s20(2000)});
		endcase
		a = rand_s20(3000);
		b = rand_s20(3000);
		case ($urandom_range(0, 3))
			0: write_reg(roicrop_pkg::CFG_HEIGHT, {20'b0, 20'sd524287, -20'sd524288});
			1: write_reg(roicrop_pkg::CFG_HEIGHT, rand60());
			default: write_reg(roicrop_pkg::CFG_HEIGHT,
				{20'b0, ($signed(a) > $signed(b)) ? {a, b} : {b, a}});
		endcase
		a = 20'($urandom_range(0, 3000));
		b = 20'($urandom_range(0, 6000));
		case ($urandom_range(0, 3))
			0: write_reg(roicrop_pkg::CFG_RANGE, {20'b0, 20'hFFFFF, 20'h0});
			1: write_reg(roicrop_pkg::CFG_RANGE, rand60());
			default: write_reg(roicrop_pkg::CFG_RANGE, {20'b0, b, a});
		endcase
		c = 16'($urandom);
		e = 16'($urandom);
		case ($urandom_range(0, 3))
			0: write_reg(roicrop_pkg::CFG_ANGLE, {28'b0, 16'h7FFF, 16'h8000});
			1: write_reg(roicrop_pkg::CFG_ANGLE, {28'b0, c, e});
			default: write_reg(roicrop_pkg::CFG_ANGLE,
				{28'b0, ($signed(c) > $signed(e)) ? {c, e} : {e, c}});
		endcase
		write_reg(CFG_UNUSED, rand60());
	endtask

	function automatic roicrop_pkg::point_t random_point();
		roicrop_pkg::point_t p;
		if ($urandom_range(0, 9) == 0) begin
			p.point_x = 20'($urandom);
			p.point_y = 20'($urandom);
			p.point_z = 20'($urandom);
		end else begin
			p.point_x = rand_s20(6000);
			p.point_y = rand_s20(6000);
			p.point_z = rand_s20(3000);
		end
		p.point_valid = ($urandom_range(0, 9) != 0);
		p.last_point = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	initial begin
		roicrop_pkg::point_t p;
		axis_r[0] = 60'd262144;
		axis_r[1] = 60'd274877906944;
		axis_r[2] = 60'd288230376151711744;
		origin_r = '0;
		height_r = 40'd1048576000;
		range_r = 40'd4194304450;
		angle_r = 32'd1073790976;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed points against the reset configuration
		foreach (DIRECTED[i]) begin
			p.point_x = DIRECTED[i].x;
			p.point_y = DIRECTED[i].y;
			p.point_z = DIRECTED[i].z;
			p.point_valid = DIRECTED[i].vld;
			p.last_point = DIRECTED[i].lst;
			send_point(p);
			// overwrite the predicted keep flag with the typed one
			if (DIRECTED[i].typed)
				expected_results[expected_results.size() - 1].keep = DIRECTED[i].keep;
		end

		// random phases, each under a fresh configuration
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_pipeline();
			configure_random();
			if (ph == 1)
				rx_hold_req = 1;
			if (ph == NUM_PHASES - 1) begin
				tx_quiet = 1;
				rx_quiet = 1;
			end
			for (int n = 0; n < POINTS_PER_PHASE; n++) begin
				send_point(random_point());
				// in phase 2, halfway through, pause the sender until the pipeline empties
				if (ph == 2 && n == POINTS_PER_PHASE / 2)
					drain_pipeline();
			end
		end

		drain_pipeline();
		$display("covered %0d points in %0d configurations, %0d results, %0d kept",
			points_sent, NUM_PHASES + 1, results_seen, kept_seen);
		if (errors == 0)
			$display("point_roi_crop_filter_unit_tb: PASS");
		else
			$display("point_roi_crop_filter_unit_tb: FAIL");
		$finish;
	end

endmodule

### point_roi_crop_filter_unit.f
+incdir+rtl
rtl/roicrop_pkg.sv
rtl/roicrop_proj.sv
rtl/roicrop_cordic.sv
rtl/roicrop_skid.sv
rtl/point_roi_crop_filter_unit.sv
tb/point_roi_crop_filter_unit_tb.sv
